>>> hw/rtl/gte_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal engine package
// Shared constants, payload structs, state encoding and stack entry layout.
// ----------------------------------------------------------------------------
package gte_pkg;

    // Graph capacity.
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;

    // Field widths fixed by the interface.
    localparam int VTX_W  = 6;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 7;

    // Derived widths.
    localparam int VA_W    = $clog2(MAX_VERTICES);      // vertex-indexed storage address
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);  // queue and stack occupancy
    localparam int EDGE_AW = $clog2(MAX_EDGES);         // edge store address
    localparam int EDGE_CW = $clog2(MAX_EDGES + 1);     // edge count and resume index
    localparam int EDGE_W  = 2 * VTX_W;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(64);

    // Opcodes.
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_BFS      = 2'd1;
    localparam logic [OP_W-1:0] OP_DFS      = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_VTX   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_STORE_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [VTX_W-1:0] first_vertex;
        logic [VTX_W-1:0] second_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0]  visited_vertex;
        logic              last;
        logic [STAT_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [VTX_W-1:0]   vertex;
        logic [EDGE_CW-1:0] pos;
    } t_stack_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_EMIT,
        ST_SCAN,
        ST_B_POP,
        ST_B_LOAD,
        ST_D_POP,
        ST_D_LOAD
    } t_state;

endpackage

>>> hw/rtl/gte_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/graph_traversal_engine.sv
// ----------------------------------------------------------------------------
// Graph traversal engine
// Edge store with breadth-first and depth-first traversal of an undirected
// graph, one visited vertex per result transfer.
// ----------------------------------------------------------------------------
// Input transfers carry an opcode and two vertices. Add edge appends one
// undirected edge and answers with a single result whose status reports
// success, an out-of-range vertex or a full store. A traversal answers with
// one result per visited vertex in traversal order, the final one marked by
// last, or with a single bad-vertex result if its start vertex is out of
// range. Opcode 3 is consumed without a result. The vertex_count register
// is written through i_cfg_we/i_cfg_data; the user must write it only while
// the engine is idle, which the block itself does not enforce. One item is
// handled at a time and o_in_ready stays low until it is done. A traversal
// scans the whole edge store through the edge RAM read port once per visited
// vertex, one edge per cycle. Each vertex waits in a hold stage until the
// next one or the end is known, so last is exact. A stalled receiver pauses
// the search at its next emitted vertex. Reset empties the edge store, sets
// the vertex count to 64 and leaves the engine ready.
// ----------------------------------------------------------------------------
module graph_traversal_engine
    import gte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Control and payload registers.
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [VTX_W-1:0]    r_x, n_x;              // vertex whose neighbours are scanned
    logic [EDGE_CW-1:0]  r_pos, n_pos;          // edge index the scan starts from
    logic [CNT_W-1:0]    r_sp, n_sp;            // stack depth, top entry held in r_x/r_pos
    logic [CNT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_tail, n_tail;
    logic [EDGE_CW-1:0]  r_scan_idx, n_scan_idx;
    logic                r_dvalid, n_dvalid;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [EDGE_CW-1:0]  r_edge_count, n_edge_count;
    logic [CFG_W-1:0]    r_vertex_count;
    logic [VTX_W-1:0]    r_emit_v, n_emit_v;
    logic [VTX_W-1:0]    r_hold_v, n_hold_v;
    logic                r_hold_valid, n_hold_valid;
    logic [STAT_W-1:0]   r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // Memory ports.
    logic                e_we;
    logic [EDGE_AW-1:0]  e_waddr, e_raddr;
    logic [EDGE_W-1:0]   e_wdata, e_rdata;
    logic                q_we;
    logic [VA_W-1:0]     q_waddr, q_raddr;
    logic [VTX_W-1:0]    q_wdata, q_rdata;
    logic                s_we;
    logic [VA_W-1:0]     s_waddr, s_raddr;
    t_stack_entry        s_wdata, s_rdata;

    // Combinational helpers.
    logic [CFG_W-1:0]    w_vc;
    logic                w_out_free;
    logic                w_issue;
    logic [VTX_W-1:0]    w_ea, w_eb, w_nb;
    logic                w_touch;
    logic                w_hit;
    logic                w_bad_u, w_bad_w;
    logic [CNT_W-1:0]    w_sp_m1, w_sp_m2;

    gte_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    gte_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    gte_ram #(
        .WIDTH ($bits(t_stack_entry)),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // The effective vertex count saturates at the capacity of the engine.
    assign w_vc = (r_vertex_count > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES)
                                                         : r_vertex_count;

    assign w_bad_u = {1'b0, i_in_data.first_vertex}  >= w_vc;
    assign w_bad_w = {1'b0, i_in_data.second_vertex} >= w_vc;

    // The output register can take a new result when it is empty or when
    // its current result transfers in this cycle.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Neighbour test on the edge that was read in the previous cycle. An
    // edge whose far end lies beyond the current vertex count is ignored.
    assign w_ea = e_rdata[EDGE_W-1:VTX_W];
    assign w_eb = e_rdata[VTX_W-1:0];

    always_comb begin
        w_touch = 1'b1;
        w_nb    = w_eb;
        if (w_ea == r_x) begin
            w_nb = w_eb;
        end else if (w_eb == r_x) begin
            w_nb = w_ea;
        end else begin
            w_touch = 1'b0;
        end
    end

    assign w_hit = r_dvalid && w_touch && ({1'b0, w_nb} < w_vc)
                   && !r_visited[w_nb[VA_W-1:0]];

    assign w_issue = r_scan_idx < r_edge_count;
    assign w_sp_m1 = r_sp - CNT_W'(1);
    assign w_sp_m2 = r_sp - CNT_W'(2);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_x          = r_x;
        n_pos        = r_pos;
        n_sp         = r_sp;
        n_head       = r_head;
        n_tail       = r_tail;
        n_scan_idx   = r_scan_idx;
        n_dvalid     = 1'b0;
        n_visited    = r_visited;
        n_edge_count = r_edge_count;
        n_emit_v     = r_emit_v;
        n_hold_v     = r_hold_v;
        n_hold_valid = r_hold_valid;
        n_status     = r_status;
        n_out        = r_out;
        n_out_valid  = i_out_ready ? 1'b0 : r_out_valid;

        o_in_ready   = 1'b0;

        e_we    = 1'b0;
        e_waddr = r_edge_count[EDGE_AW-1:0];
        e_wdata = {i_in_data.first_vertex, i_in_data.second_vertex};
        e_raddr = r_scan_idx[EDGE_AW-1:0];
        q_we    = 1'b0;
        q_waddr = r_tail[VA_W-1:0];
        q_wdata = w_nb;
        q_raddr = r_head[VA_W-1:0];
        s_we    = 1'b0;
        s_waddr = w_sp_m1[VA_W-1:0];
        s_wdata = '{vertex: r_x, pos: r_scan_idx};
        s_raddr = w_sp_m2[VA_W-1:0];

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op = i_in_data.opcode;
                    case (i_in_data.opcode)
                        OP_ADD_EDGE: begin
                            n_state = ST_RESP;
                            if (w_bad_u || w_bad_w) begin
                                n_status = STAT_BAD_VTX;
                            end else if (r_edge_count >= EDGE_CW'(MAX_EDGES)) begin
                                n_status = STAT_STORE_FULL;
                            end else begin
                                n_status     = STAT_OK;
                                e_we         = 1'b1;
                                n_edge_count = r_edge_count + EDGE_CW'(1);
                            end
                        end
                        OP_BFS, OP_DFS: begin
                            if (w_bad_u) begin
                                n_status = STAT_BAD_VTX;
                                n_state  = ST_RESP;
                            end else begin
                                n_visited = '0;
                                n_visited[i_in_data.first_vertex[VA_W-1:0]] = 1'b1;
                                n_hold_valid = 1'b0;
                                n_x   = i_in_data.first_vertex;
                                n_pos = '0;
                                if (i_in_data.opcode == OP_BFS) begin
                                    // Seed the queue; the start vertex is emitted at its pop.
                                    q_we    = 1'b1;
                                    q_waddr = '0;
                                    q_wdata = i_in_data.first_vertex;
                                    n_head  = '0;
                                    n_tail  = CNT_W'(1);
                                    n_state = ST_B_POP;
                                end else begin
                                    // The start vertex is the stack top and is emitted first.
                                    n_sp     = CNT_W'(1);
                                    n_emit_v = i_in_data.first_vertex;
                                    n_state  = ST_EMIT;
                                end
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RESP: begin
                if (w_out_free) begin
                    n_out       = '{visited_vertex: '0, last: 1'b1, status: r_status};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_EMIT: begin
                // The new vertex replaces the held one, which goes out
                // without last since another result now follows it.
                if (!r_hold_valid || w_out_free) begin
                    if (r_hold_valid) begin
                        n_out       = '{visited_vertex: r_hold_v, last: 1'b0,
                                        status: STAT_OK};
                        n_out_valid = 1'b1;
                    end
                    n_hold_v     = r_emit_v;
                    n_hold_valid = 1'b1;
                    n_scan_idx   = r_pos;
                    n_state      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (w_issue) begin
                    n_scan_idx = r_scan_idx + EDGE_CW'(1);
                    n_dvalid   = 1'b1;
                end
                if (r_op == OP_BFS) begin
                    if (w_hit && (r_tail < CNT_W'(MAX_VERTICES))) begin
                        n_visited[w_nb[VA_W-1:0]] = 1'b1;
                        q_we   = 1'b1;
                        n_tail = r_tail + CNT_W'(1);
                    end
                    if (!w_issue && !r_dvalid) begin
                        n_state = ST_B_POP;
                    end
                end else begin
                    if (w_hit) begin
                        // Descend: if the stack has room, save the current top with its
                        // resume index, and the neighbour becomes the new top.
                        n_visited[w_nb[VA_W-1:0]] = 1'b1;
                        n_emit_v = w_nb;
                        n_dvalid = 1'b0;
                        n_state  = ST_EMIT;
                        if (r_sp < CNT_W'(MAX_VERTICES)) begin
                            s_we  = 1'b1;
                            n_x   = w_nb;
                            n_pos = '0;
                            n_sp  = r_sp + CNT_W'(1);
                        end else begin
                            n_pos = r_scan_idx;
                        end
                    end else if (!w_issue && !r_dvalid) begin
                        n_state = ST_D_POP;
                    end
                end
            end

            ST_B_POP: begin
                if (r_head < r_tail) begin
                    n_state = ST_B_LOAD;
                end else begin
                    n_state = ST_RESP;
                    if (w_out_free) begin
                        n_out       = '{visited_vertex: r_hold_v, last: 1'b1,
                                        status: STAT_OK};
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_B_POP;
                    end
                end
            end

            ST_B_LOAD: begin
                n_x      = q_rdata;
                n_pos    = '0;
                n_emit_v = q_rdata;
                n_head   = r_head + CNT_W'(1);
                n_state  = ST_EMIT;
            end

            ST_D_POP: begin
                if (r_sp == CNT_W'(1)) begin
                    // Stack drained: the held vertex is the final result.
                    if (w_out_free) begin
                        n_out       = '{visited_vertex: r_hold_v, last: 1'b1,
                                        status: STAT_OK};
                        n_out_valid = 1'b1;
                        n_sp        = '0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_sp    = w_sp_m1;
                    n_state = ST_D_LOAD;
                end
            end

            ST_D_LOAD: begin
                n_x        = s_rdata.vertex;
                n_pos      = s_rdata.pos;
                n_scan_idx = s_rdata.pos;
                n_state    = ST_SCAN;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_dvalid       <= 1'b0;
            r_visited      <= '0;
            r_edge_count   <= '0;
            r_vertex_count <= VERTEX_COUNT_RESET;
            r_hold_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dvalid     <= n_dvalid;
            r_visited    <= n_visited;
            r_edge_count <= n_edge_count;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_pos      <= n_pos;
        r_sp       <= n_sp;
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_scan_idx <= n_scan_idx;
        r_emit_v   <= n_emit_v;
        r_hold_v   <= n_hold_v;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> tb/sv/tb_graph_traversal_engine.sv
// ----------------------------------------------------------------------------
// Graph traversal engine testbench
// Loads undirected edges, runs breadth-first and depth-first traversals under
// several vertex counts, and checks every visited-vertex transfer against a
// behavioral traversal kept in step with each accepted command.
// ----------------------------------------------------------------------------
module tb_graph_traversal_engine;
    import gte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth opcode is not named by the package. The engine consumes it
    // without producing a result.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // After the last pending result has arrived, a spare opcode may still be
    // in flight. Wait this long before touching the vertex count register.
    localparam int IDLE_GAP = 64;
    // A depth-first backtrack over a full store scans the rest of the edge store
    // for each stack entry without a single transfer. Allow several times that.
    localparam int QUIET_LIMIT = 100000;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 500;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    graph_traversal_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the engine state.
    // ------------------------------------------------------------------------
    logic [EDGE_W-1:0]       edge_mem [MAX_EDGES];
    int                      edge_total = 0;
    logic [CFG_W-1:0]        vtx_limit = VERTEX_COUNT_RESET;
    logic [MAX_VERTICES-1:0] visit_marks;
    t_out_item               step_out[$];

    // Results still owed by the engine, oldest first.
    t_out_item visits_due[$];
    int        bad_count = 0;

    // Other end of edge i as seen from vertex x, or -1 when the edge does not
    // touch x or leads to a vertex that is out of range under the current
    // vertex count (a stale edge after the count was lowered).
    function automatic int far_end(int i, int x, int vc);
        int a;
        int b;
        int n;
        a = edge_mem[i][EDGE_W-1:VTX_W];
        b = edge_mem[i][VTX_W-1:0];
        if (a == x) n = b;
        else if (b == x) n = a;
        else return -1;
        if (n >= vc) return -1;
        return n;
    endfunction

    // Marks a vertex visited and records it as a result, up to MAX_VERTICES
    // results per command.
    function automatic void note_visit(int v);
        t_out_item r;
        r.visited_vertex = VTX_W'(v);
        r.last = 1'b0;
        r.status = STAT_OK;
        if (step_out.size() < MAX_VERTICES) step_out = {step_out, r};
        visit_marks[v] = 1'b1;
    endfunction

    // Applies one accepted command to the behavioral state and leaves the
    // results it causes in step_out.
    function automatic void walk_graph(input t_in_item it);
        int        vc;
        int        u;
        int        w;
        int        head;
        int        tail;
        int        sp;
        int        t;
        int        x;
        int        n;
        bit        found;
        int        bfs_q [MAX_VERTICES];
        int        stk_v [MAX_VERTICES];
        int        stk_pos [MAX_VERTICES];
        t_out_item r;
        step_out.delete();
        // The register saturates at the vertex capacity; zero puts every
        // vertex out of range.
        vc = (vtx_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_limit);
        u = it.first_vertex;
        w = it.second_vertex;
        r.visited_vertex = '0;
        r.last = 1'b1;
        r.status = STAT_OK;
        case (it.opcode)
            OP_ADD_EDGE: begin
                // Range is checked before capacity.
                if (u >= vc || w >= vc) begin
                    r.status = STAT_BAD_VTX;
                end else if (edge_total >= MAX_EDGES) begin
                    r.status = STAT_STORE_FULL;
                end else begin
                    edge_mem[edge_total] = {it.first_vertex, it.second_vertex};
                    edge_total++;
                end
                step_out = {step_out, r};
            end
            OP_BFS, OP_DFS: begin
                if (u >= vc) begin
                    r.status = STAT_BAD_VTX;
                    step_out = {step_out, r};
                end else begin
                    visit_marks = '0;
                    if (it.opcode == OP_BFS) begin
                        head = 0;
                        tail = 1;
                        bfs_q[0] = u;
                        visit_marks[u] = 1'b1;
                        while (head < tail) begin
                            x = bfs_q[head % MAX_VERTICES];
                            head++;
                            note_visit(x);
                            for (int i = 0; i < edge_total; i++) begin
                                n = far_end(i, x, vc);
                                if (n >= 0 && !visit_marks[n] && tail < MAX_VERTICES) begin
                                    visit_marks[n] = 1'b1;
                                    bfs_q[tail] = n;
                                    tail++;
                                end
                            end
                        end
                    end else begin
                        // Preorder: each frame resumes its edge scan where the
                        // last descent left it.
                        note_visit(u);
                        stk_v[0] = u;
                        stk_pos[0] = 0;
                        sp = 1;
                        while (sp > 0) begin
                            t = sp - 1;
                            x = stk_v[t];
                            found = 1'b0;
                            for (int i = stk_pos[t]; i < edge_total && !found; i++) begin
                                n = far_end(i, x, vc);
                                if (n >= 0 && !visit_marks[n]) begin
                                    stk_pos[t] = i + 1;
                                    note_visit(n);
                                    if (sp < MAX_VERTICES) begin
                                        stk_v[sp] = n;
                                        stk_pos[sp] = 0;
                                        sp++;
                                    end
                                    found = 1'b1;
                                end
                            end
                            if (!found) sp--;
                        end
                    end
                    step_out[step_out.size() - 1].last = 1'b1;
                end
            end
            default: begin
                // Spare opcode: no result, no state change.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge, so the
    // prediction for a command is queued in the same step it is accepted.
    // ------------------------------------------------------------------------
    logic      drv_typed = 1'b0;   // current command carries a typed-in result
    t_out_item drv_want = '0;

    function automatic void flag(string why, t_out_item want, t_out_item got);
        bad_count++;
        if (bad_count <= 10)
            $display({"%0t: %s: vertex exp %0d got %0d, last exp %0b got %0b,",
                      " status exp %0d got %0d"},
                     $realtime, why, want.visited_vertex, got.visited_vertex,
                     want.last, got.last, want.status, got.status);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                walk_graph(i_in_data);
                // Typed rows still run the traversal so that the state stays in
                // step, but the hand-written result is what gets checked.
                if (drv_typed) visits_due = {visits_due, drv_want};
                else foreach (step_out[j]) visits_due = {visits_due, step_out[j]};
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (visits_due.size() == 0) begin
                    flag("result with nothing pending", '0, got);
                end else begin
                    want = visits_due.pop_front();
                    if (got.visited_vertex !== want.visited_vertex ||
                        got.last !== want.last || got.status !== want.status)
                        flag("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver pacing. The pace mode is redrawn at random among always ready,
    // coin-flip ready and a rotating bit pattern. When the stimulus asks
    // for it, the receiver stops taking results for a long stretch so that the
    // engine's output stage fills up and it pushes back on its input.
    // ------------------------------------------------------------------------
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          pace_mode = 0;
    int          pace_left = 0;
    logic [15:0] pace_bits = '1;

    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (pace_left == 0) begin
            pace_mode = $urandom_range(0, 2);
            pace_left = $urandom_range(20, 120);
            pace_bits = 16'($urandom);
        end
        pace_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (pace_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    i_out_ready <= pace_bits[0];
                    pace_bits = {pace_bits[0], pace_bits[15:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Tasks start and end just after a falling edge, where all inputs
    // change. In bursty mode valid drops for a random gap between bursts.
    // ------------------------------------------------------------------------
    bit bursty = 1'b0;
    int burst_left = 0;

    task automatic offer(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        i_in_data = it;
        drv_typed = typed;
        drv_want = want;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 8);
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(0, 10);
            end
        end
    endtask

    // Stops offering and waits for the engine to go idle.
    task automatic settle();
        i_in_valid = 1'b0;
        while (visits_due.size() != 0) @(negedge i_clk);
        repeat (IDLE_GAP) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [CFG_W-1:0] v);
        settle();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        vtx_limit = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_in_item make_item(logic [OP_W-1:0] op, int a, int b);
        t_in_item it;
        it.opcode = op;
        it.first_vertex = VTX_W'(a);
        it.second_vertex = VTX_W'(b);
        return it;
    endfunction

    // Random command for a phase whose effective vertex count is vc. Most
    // commands are well-formed adds and traversals inside the range; the rest
    // use the full field range or the spare opcode.
    function automatic t_in_item random_item(int vc);
        int  pick;
        int  hi;
        pick = $urandom_range(0, 99);
        hi = (vc > 0) ? vc - 1 : 0;
        if (pick < 50 && vc > 0)
            return make_item(OP_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi));
        if (pick < 60)
            return make_item(OP_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63));
        if (pick < 88)
            return make_item($urandom_range(0, 1) ? OP_BFS : OP_DFS,
                             ($urandom_range(0, 9) != 0) ? $urandom_range(0, hi)
                                                         : $urandom_range(0, 63),
                             $urandom_range(0, 63));
        return make_item(OP_SPARE, $urandom_range(0, 63), $urandom_range(0, 63));
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: a row is either a vertex count write or a command,
    // optionally with the single result it must produce.
    // ------------------------------------------------------------------------
    typedef struct {
        bit               cfg_write;
        logic [CFG_W-1:0] cfg_value;
        t_in_item         item;
        bit               typed;
        t_out_item        want;
    } t_stim_row;

    t_stim_row dir_rows[$];

    function automatic void add_row(t_stim_row r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic t_stim_row cmd(logic [OP_W-1:0] op, int a, int b);
        t_stim_row r;
        r.cfg_write = 1'b0;
        r.cfg_value = '0;
        r.item = make_item(op, a, b);
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_stim_row cmd_chk(logic [OP_W-1:0] op, int a, int b, int v,
                                          logic [STAT_W-1:0] st);
        t_stim_row r;
        r = cmd(op, a, b);
        r.typed = 1'b1;
        r.want.visited_vertex = VTX_W'(v);
        r.want.last = 1'b1;
        r.want.status = st;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(int v);
        t_stim_row r;
        r = cmd(OP_SPARE, 0, 0);
        r.cfg_write = 1'b1;
        r.cfg_value = CFG_W'(v);
        return r;
    endfunction

    // Vertex counts for the random phases: full range, small graphs, the
    // saturating top value, a single vertex and zero.
    int phase_counts[10] = '{64, 8, 127, 3, 16, 1, 64, 24, 0, 40};

    initial begin : stimulus
        int vc;
        // On an empty graph a traversal visits only its start vertex.
        add_row(cmd_chk(OP_BFS, 0, 0, 0, STAT_OK));
        add_row(cmd_chk(OP_DFS, 63, 0, 63, STAT_OK));
        add_row(cmd(OP_SPARE, 63, 63));
        add_row(cmd_chk(OP_ADD_EDGE, 0, 63, 0, STAT_OK));
        add_row(cmd_chk(OP_ADD_EDGE, 63, 0, 0, STAT_OK));
        add_row(cmd_chk(OP_ADD_EDGE, 5, 5, 0, STAT_OK));     // self loop
        add_row(cmd_chk(OP_ADD_EDGE, 0, 5, 0, STAT_OK));
        add_row(cmd_chk(OP_ADD_EDGE, 63, 42, 0, STAT_OK));
        add_row(cmd_chk(OP_ADD_EDGE, 42, 31, 0, STAT_OK));
        add_row(cmd(OP_BFS, 0, 0));
        add_row(cmd(OP_DFS, 0, 63));
        add_row(cmd(OP_BFS, 63, 0));
        add_row(cmd(OP_DFS, 31, 0));
        // Lowered count: out-of-range endpoints are refused, and edges into
        // the upper half become invisible to traversals.
        add_row(cfg_row(32));
        add_row(cmd_chk(OP_ADD_EDGE, 40, 1, 0, STAT_BAD_VTX));
        add_row(cmd_chk(OP_ADD_EDGE, 1, 32, 0, STAT_BAD_VTX));
        add_row(cmd(OP_BFS, 0, 0));
        add_row(cmd_chk(OP_DFS, 32, 0, 0, STAT_BAD_VTX));
        // A count of zero rejects every vertex.
        add_row(cfg_row(0));
        add_row(cmd_chk(OP_ADD_EDGE, 0, 0, 0, STAT_BAD_VTX));
        add_row(cmd_chk(OP_BFS, 0, 0, 0, STAT_BAD_VTX));
        // Top register value saturates at the vertex capacity.
        add_row(cfg_row(127));
        add_row(cmd(OP_DFS, 42, 0));
        add_row(cfg_row(1));
        add_row(cmd_chk(OP_ADD_EDGE, 0, 0, 0, STAT_OK));
        add_row(cmd(OP_BFS, 0, 0));
        add_row(cmd_chk(OP_DFS, 1, 0, 0, STAT_BAD_VTX));

        // Synchronous reset, released at a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        bursty = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_write) write_vertex_count(dir_rows[i].cfg_value);
            else offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each under its own vertex count.
        foreach (phase_counts[p]) begin
            write_vertex_count(CFG_W'(phase_counts[p]));
            vc = (phase_counts[p] > MAX_VERTICES) ? MAX_VERTICES : phase_counts[p];
            bursty = (p % 3 != 0);
            if (p == 2) begin
                // Receiver stops for a long stretch while adds keep coming
                // back to back, so the engine has to stall its input.
                bursty = 1'b0;
                hold_asks++;
                repeat (12)
                    offer(make_item(OP_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63)),
                          1'b0, '0);
                bursty = 1'b1;
            end
            repeat (10) offer(random_item(vc), 1'b0, '0);
        end

        // Fill the edge store to capacity, then probe the full-store code and
        // traverse the densest graph the store can hold.
        write_vertex_count(CFG_W'(64));
        bursty = 1'b1;
        while (edge_total < MAX_EDGES)
            offer(make_item(OP_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63)),
                  1'b0, '0);
        bursty = 1'b0;
        offer(make_item(OP_ADD_EDGE, 10, 20), 1'b1, '{visited_vertex: '0, last: 1'b1,
                                                     status: STAT_STORE_FULL});
        write_vertex_count(CFG_W'(50));
        // The range check wins over the full store.
        offer(make_item(OP_ADD_EDGE, 55, 3), 1'b1, '{visited_vertex: '0, last: 1'b1,
                                                     status: STAT_BAD_VTX});
        offer(make_item(OP_ADD_EDGE, 1, 2), 1'b1, '{visited_vertex: '0, last: 1'b1,
                                                    status: STAT_STORE_FULL});
        offer(make_item(OP_BFS, 0, 0), 1'b0, '0);
        offer(make_item(OP_DFS, 49, 0), 1'b0, '0);
        write_vertex_count(CFG_W'(64));
        bursty = 1'b1;
        offer(make_item(OP_BFS, 63, 0), 1'b0, '0);
        offer(make_item(OP_DFS, 63, 0), 1'b0, '0);

        // Drain. The watchdog bounds this wait.
        i_in_valid = 1'b0;
        while (visits_due.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        if (bad_count == 0 && visits_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/gte_pkg.sv
hw/rtl/gte_ram.sv
hw/rtl/graph_traversal_engine.sv
tb/sv/tb_graph_traversal_engine.sv
